### rtl/cdd_pkg.sv
// Shared types, constants and calendar helpers for the date decrementer.
package cdd_pkg;

    localparam int YearW   = 16;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int AmountW = 15;
    localparam int ActionW = 3;
    // weeks need amount * 7 steps
    localparam int CountW  = AmountW + 3;

    // floor(a / 25) == (a * Recip25) >> Recip25Shift for a <= 32768
    localparam int Recip25      = 41944;
    localparam int Recip25Shift = 20;
    localparam int ProdW        = 32;
    localparam int QuotW        = ProdW - Recip25Shift;

    localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
    localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
    localparam logic [MonthW-1:0] MonthDec = MonthW'(12);
    localparam logic [DayW-1:0]   DayFirst = DayW'(1);
    localparam logic [DayW-1:0]   DayLong  = DayW'(31);

    typedef enum logic [ActionW-1:0] {
        ACT_LOAD   = 3'd0,
        ACT_DAYS   = 3'd1,
        ACT_WEEKS  = 3'd2,
        ACT_MONTHS = 3'd3,
        ACT_YEARS  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT1,
        ST_WAIT2,
        ST_EXEC,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLAMP,
        OP_DAY,
        OP_MONTH,
        OP_YEARS
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        op_t  op;
        logic capture;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        action_t action;
        logic    count_zero;
    } dp_status_t;

    // length of a month; codes outside 1..12 read as 31
    function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                   input logic leap);
        logic [DayW-1:0] len;
        begin
            unique case (m)
                4'd2:                       len = leap ? DayW'(29) : DayW'(28);
                4'd4, 4'd6, 4'd9, 4'd11:    len = DayW'(30);
                default:                    len = DayW'(31);
            endcase
            return len;
        end
    endfunction

endpackage

### rtl/calendar_date_decrementer_top.sv
// Gregorian date decrementer: holds a date and applies one command per word.
//
// Input stream (s_): each word is a command: load a date, or subtract days,
// weeks, months or years from the held date. Output stream (m_): one word
// per command with the resulting date.
// Each command passes the sequencer states WAIT1, WAIT2, EXEC and
// DONE before m_tvalid rises; days, weeks and months stay in EXEC
// until the step counter, loaded with the amount (seven times it for
// weeks), reaches zero. The day and month loops step the date back
// one calendar step per cycle, and every command first waits in WAIT1
// and WAIT2 for the pipelined leap year detector to follow the held
// year. One command is in flight at a time; s_tready is high while the
// sequencer is idle, so a command is taken after the last leaves DONE.
// The result sits in an output register; a stalled receiver holds it
// there while the next command is accepted, which then waits to deliver
// its own result until the register frees up.
// Reset (aresetn low, synchronous) returns the sequencer to idle, holds
// s_tready low and drops m_tvalid; the held date is not cleared and must
// be loaded before any subtract command.
module calendar_date_decrementer_top
    import cdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] action, [17:3] amount, [33:18] load_year, [37:34] load_month,
    // [42:38] load_day, [47:43] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] year, [19:16] month, [24:20] day, [31:25] zero
    output logic [31:0] m_tdata
);

    dp_cmd_t                 cmd;
    dp_status_t              status;
    logic signed [YearW-1:0] out_year;
    logic [MonthW-1:0]       out_month;
    logic [DayW-1:0]         out_day;

    cdd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    cdd_datapath u_datapath (
        .aclk      (aclk),
        .cmd       (cmd),
        .status    (status),
        .in_action (s_tdata[2:0]),
        .in_amount (s_tdata[17:3]),
        .in_year   (s_tdata[33:18]),
        .in_month  (s_tdata[37:34]),
        .in_day    (s_tdata[42:38]),
        .out_year  (out_year),
        .out_month (out_month),
        .out_day   (out_day)
    );

    assign m_tdata = {7'b0, out_day, out_month, out_year};

endmodule

### rtl/cdd_leap.sv
// Two-stage leap year detector that tracks the stored year.
module cdd_leap
    import cdd_pkg::*;
(
    input  logic                    aclk,
    input  logic signed [YearW-1:0] year,
    output logic                    leap
);

    logic [YearW-1:0] mag;
    logic [ProdW-1:0] prod_reg, prod_next;
    logic [YearW-1:0] mag_reg;
    logic [QuotW-1:0] quot;
    logic [YearW-1:0] quot_x25;
    logic             div25;
    logic             leap_reg, leap_next;

    // magnitude (-32768 gives 32768) and reciprocal multiply by 1/25
    always_comb begin
        mag       = year[YearW-1] ? YearW'(-year) : YearW'(year);
        prod_next = ProdW'(mag) * ProdW'(Recip25);
    end

    // remainder test: divisible by 25 when quotient * 25 gives back the value
    always_comb begin
        quot      = prod_reg[ProdW-1:Recip25Shift];
        quot_x25  = YearW'({quot, 4'b0}) + YearW'({quot, 3'b0}) + YearW'(quot);
        div25     = (quot_x25 == mag_reg);
        // div by 25: leap needs div by 16 (400); otherwise div by 4
        leap_next = div25 ? (mag_reg[3:0] == 4'd0) : (mag_reg[1:0] == 2'd0);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        mag_reg  <= mag;
        leap_reg <= leap_next;
    end

    assign leap = leap_reg;

endmodule

### rtl/cdd_datapath.sv
// Date registers, step counter and result word register.
module cdd_datapath
    import cdd_pkg::*;
(
    input  logic                    aclk,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic [ActionW-1:0]      in_action,
    input  logic [AmountW-1:0]      in_amount,
    input  logic signed [YearW-1:0] in_year,
    input  logic [MonthW-1:0]       in_month,
    input  logic [DayW-1:0]         in_day,
    output logic signed [YearW-1:0] out_year,
    output logic [MonthW-1:0]       out_month,
    output logic [DayW-1:0]         out_day
);

    logic signed [YearW-1:0] year_reg, year_next;
    logic [MonthW-1:0]       month_reg, month_next;
    logic [DayW-1:0]         day_reg, day_next;
    logic [CountW-1:0]       count_reg, count_next;
    action_t                 action_reg, action_next;
    logic signed [YearW-1:0] oyear_reg, oyear_next;
    logic [MonthW-1:0]       omonth_reg, omonth_next;
    logic [DayW-1:0]         oday_reg, oday_next;
    logic                    leap;
    logic [MonthW-1:0]       month_prev;
    logic [DayW-1:0]         len_cur, len_prev;

    cdd_leap u_leap (
        .aclk (aclk),
        .year (year_reg),
        .leap (leap)
    );

    always_comb begin
        month_prev = month_reg - MonthW'(1);
        len_cur    = month_days(month_reg, leap);
        len_prev   = month_days(month_prev, leap);
    end

    // next date and counter
    always_comb begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        count_next  = count_reg;
        action_next = action_reg;
        if (cmd.accept) begin
            action_next = action_t'(in_action);
            if (action_t'(in_action) == ACT_WEEKS)
                count_next = CountW'({in_amount, 3'b0}) - CountW'(in_amount);
            else
                count_next = CountW'(in_amount);
            if (action_t'(in_action) == ACT_LOAD) begin
                year_next = in_year;
                day_next  = in_day;
                if (in_month < MonthJan)
                    month_next = MonthJan;
                else if (in_month > MonthDec)
                    month_next = MonthDec;
                else
                    month_next = in_month;
            end
        end else begin
            unique case (cmd.op)
                OP_CLAMP: begin
                    if (day_reg < DayFirst)
                        day_next = DayFirst;
                    else if (day_reg > len_cur)
                        day_next = len_cur;
                end
                OP_DAY: begin
                    count_next = count_reg - CountW'(1);
                    if (day_reg == DayFirst) begin
                        if (month_reg == MonthJan) begin
                            month_next = MonthDec;
                            day_next   = DayLong;
                            year_next  = year_reg - YearW'(1);
                        end else begin
                            month_next = month_prev;
                            day_next   = len_prev;
                        end
                    end else begin
                        day_next = day_reg - DayW'(1);
                    end
                end
                OP_MONTH: begin
                    count_next = count_reg - CountW'(1);
                    if (month_reg == MonthJan) begin
                        // December has 31 days, no clamp possible
                        month_next = MonthDec;
                        year_next  = year_reg - YearW'(1);
                    end else begin
                        month_next = month_prev;
                        if (day_reg > len_prev)
                            day_next = len_prev;
                    end
                end
                OP_YEARS: begin
                    year_next = year_reg - YearW'({1'b0, count_reg[AmountW-1:0]});
                end
                default: begin
                end
            endcase
        end
    end

    // result word
    always_comb begin
        oyear_next  = oyear_reg;
        omonth_next = omonth_reg;
        oday_next   = oday_reg;
        if (cmd.capture) begin
            oyear_next  = year_reg;
            omonth_next = month_reg;
            oday_next   = day_reg;
        end
    end

    always_ff @(posedge aclk) begin
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        count_reg  <= count_next;
        action_reg <= action_next;
        oyear_reg  <= oyear_next;
        omonth_reg <= omonth_next;
        oday_reg   <= oday_next;
    end

    assign status.action     = action_reg;
    assign status.count_zero = (count_reg == '0);
    assign out_year          = oyear_reg;
    assign out_month         = omonth_reg;
    assign out_day           = oday_reg;

endmodule

### rtl/cdd_ctrl.sv
// Command sequencer and output valid flag.
module cdd_ctrl
    import cdd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   out_free;

    assign out_free = !mvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_WAIT1;
            ST_WAIT1: state_next = ST_WAIT2;
            ST_WAIT2: state_next = ST_EXEC;
            ST_EXEC: begin
                unique case (status.action)
                    ACT_DAYS, ACT_WEEKS, ACT_MONTHS:
                        if (status.count_zero) state_next = ST_DONE;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        // no word is taken while reset is held
        s_tready    = (state_reg == ST_IDLE) && aresetn;
        cmd.accept  = s_tready && s_tvalid;
        cmd.op      = OP_NONE;
        cmd.capture = (state_reg == ST_DONE) && out_free;
        if (state_reg == ST_EXEC) begin
            unique case (status.action)
                ACT_LOAD:   cmd.op = OP_CLAMP;
                ACT_DAYS, ACT_WEEKS:
                    if (!status.count_zero) cmd.op = OP_DAY;
                ACT_MONTHS:
                    if (!status.count_zero) cmd.op = OP_MONTH;
                ACT_YEARS:  cmd.op = OP_YEARS;
                default:    cmd.op = OP_NONE;
            endcase
        end
        if (cmd.capture)
            mvalid_next = 1'b1;
        else if (m_tready)
            mvalid_next = 1'b0;
        else
            mvalid_next = mvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule
